>>> rtl/qled_pkg.sv
// Shared types and constants for the quoted literal escape decoder.
// Used by qled_step and quoted_literal_escape_decoder; no dependencies.
package qled_pkg;

  // Input actions.
  localparam logic [1:0] ACT_START = 2'd0;
  localparam logic [1:0] ACT_CHAR  = 2'd1;
  localparam logic [1:0] ACT_EOF   = 2'd2;

  typedef enum logic [1:0] {
    KIND_CHAR = 2'd0,
    KIND_END  = 2'd1,
    KIND_ERR  = 2'd2
  } kind_t;

  typedef enum logic [2:0] {
    ERR_NONE        = 3'd0,
    ERR_EOF         = 3'd1,
    ERR_ILLEGAL_ESC = 3'd2,
    ERR_BAD_ESC     = 3'd3,
    ERR_BAD_HEX     = 3'd4
  } err_t;

  // Character codes recognised by the decoder.
  localparam logic [15:0] CODE_CR    = 16'h000D;
  localparam logic [15:0] CODE_TAB   = 16'h0009;
  localparam logic [15:0] CH_BSLASH  = 16'h005C;
  localparam logic [15:0] CH_QUOTE   = 16'h0022;
  localparam logic [15:0] CH_BAR     = 16'h007C;
  localparam logic [15:0] CH_LOWER_U = 16'h0075;
  localparam logic [15:0] CH_UPPER_U = 16'h0055;
  localparam logic [15:0] CH_LOWER_N = 16'h006E;
  localparam logic [15:0] CH_UPPER_N = 16'h004E;
  localparam logic [15:0] CH_LOWER_T = 16'h0074;
  localparam logic [15:0] CH_UPPER_T = 16'h0054;

  typedef struct packed {
    logic [1:0]  action;
    logic        string_mode;
    logic [15:0] ch;
  } in_t;

  typedef struct packed {
    kind_t       kind;
    logic [15:0] out_char;
    err_t        error_code;
    logic [15:0] bad_char;
  } out_t;

  typedef struct packed {
    logic        active;
    logic        mode_string;
    logic        escape_pending;
    logic        in_hex_run;
    logic [1:0]  hex_count;
    logic [15:0] hex_accum;
  } scan_t;

  // Returns {invalid, value}; invalid is set when c is not a hex digit.
  function automatic logic [4:0] hex_value(input logic [15:0] c);
    logic [4:0] r;
    if (c >= 16'h0030 && c <= 16'h0039) begin
      r = {1'b0, c[3:0]};
    end else if ((c >= 16'h0061 && c <= 16'h0066) || (c >= 16'h0041 && c <= 16'h0046)) begin
      r = {1'b0, c[3:0] + 4'd9};
    end else begin
      r = 5'b10000;
    end
    return r;
  endfunction

endpackage

>>> rtl/qled_step.sv
// One decoding step: next scanner state and optional result for one item.
// Purely combinational; depends on qled_pkg.
module qled_step (
  input  qled_pkg::scan_t scan,
  input  qled_pkg::in_t   item,
  output qled_pkg::scan_t scan_next,
  output logic            emit,
  output qled_pkg::out_t  result
);

  logic [15:0] c;
  logic [15:0] delim;
  logic [4:0]  hv;
  logic [15:0] hex_word;

  assign c        = item.ch;
  assign delim    = scan.mode_string ? qled_pkg::CH_QUOTE : qled_pkg::CH_BAR;
  assign hv       = qled_pkg::hex_value(item.ch);
  assign hex_word = {scan.hex_accum[11:0], hv[3:0]};

  always_comb begin
    scan_next = scan;
    emit      = 1'b0;
    result    = '{kind: qled_pkg::KIND_CHAR, out_char: 16'h0000,
                  error_code: qled_pkg::ERR_NONE, bad_char: 16'h0000};

    unique case (item.action)
      qled_pkg::ACT_START: begin
        scan_next.active         = 1'b1;
        scan_next.mode_string    = item.string_mode;
        scan_next.escape_pending = 1'b0;
        scan_next.in_hex_run     = 1'b0;
        scan_next.hex_count      = 2'd0;
        scan_next.hex_accum      = 16'h0000;
      end
      qled_pkg::ACT_CHAR: begin
        if (scan.active) begin
          if (scan.escape_pending) begin
            scan_next.escape_pending = 1'b0;
            if (!scan.mode_string) begin
              emit = 1'b1;
              if (c == qled_pkg::CH_BAR || c == qled_pkg::CH_BSLASH) begin
                result.out_char = c;
              end else begin
                result.kind       = qled_pkg::KIND_ERR;
                result.error_code = qled_pkg::ERR_BAD_ESC;
              end
            end else if (c == qled_pkg::CH_LOWER_U || c == qled_pkg::CH_UPPER_U) begin
              // A second backslash-u closes the run, but only on a unit boundary.
              if (!scan.in_hex_run) begin
                scan_next.in_hex_run = 1'b1;
                scan_next.hex_count  = 2'd0;
                scan_next.hex_accum  = 16'h0000;
              end else if (scan.hex_count == 2'd0) begin
                scan_next.in_hex_run = 1'b0;
              end else begin
                emit              = 1'b1;
                result.kind       = qled_pkg::KIND_ERR;
                result.error_code = qled_pkg::ERR_ILLEGAL_ESC;
              end
            end else begin
              emit = 1'b1;
              if (scan.in_hex_run) begin
                result.kind       = qled_pkg::KIND_ERR;
                result.error_code = qled_pkg::ERR_BAD_ESC;
              end else if (c == qled_pkg::CH_LOWER_N || c == qled_pkg::CH_UPPER_N) begin
                result.out_char = qled_pkg::CODE_CR;
              end else if (c == qled_pkg::CH_LOWER_T || c == qled_pkg::CH_UPPER_T) begin
                result.out_char = qled_pkg::CODE_TAB;
              end else begin
                result.out_char = c;
              end
            end
          end else if (c == qled_pkg::CH_BSLASH) begin
            scan_next.escape_pending = 1'b1;
          end else if (c == delim) begin
            emit = 1'b1;
            if (scan.in_hex_run && scan.hex_count != 2'd0) begin
              result.kind       = qled_pkg::KIND_ERR;
              result.error_code = qled_pkg::ERR_BAD_ESC;
            end else begin
              result.kind = qled_pkg::KIND_END;
            end
          end else if (scan.in_hex_run) begin
            if (hv[4]) begin
              emit              = 1'b1;
              result.kind       = qled_pkg::KIND_ERR;
              result.error_code = qled_pkg::ERR_BAD_HEX;
              result.bad_char   = c;
            end else if (scan.hex_count == 2'd3) begin
              emit                 = 1'b1;
              result.out_char      = hex_word;
              scan_next.hex_count  = 2'd0;
              scan_next.hex_accum  = 16'h0000;
            end else begin
              scan_next.hex_accum = hex_word;
              scan_next.hex_count = scan.hex_count + 2'd1;
            end
          end else begin
            emit            = 1'b1;
            result.out_char = c;
          end
        end
      end
      qled_pkg::ACT_EOF: begin
        if (scan.active) begin
          emit              = 1'b1;
          result.kind       = qled_pkg::KIND_ERR;
          result.error_code = qled_pkg::ERR_EOF;
        end
      end
      default: begin
      end
    endcase

    // An end marker or an error closes the literal and clears the scanner.
    if (emit && result.kind != qled_pkg::KIND_CHAR) begin
      scan_next.active         = 1'b0;
      scan_next.escape_pending = 1'b0;
      scan_next.in_hex_run     = 1'b0;
      scan_next.hex_count      = 2'd0;
      scan_next.hex_accum      = 16'h0000;
    end
  end

endmodule

>>> rtl/quoted_literal_escape_decoder.sv
// Quoted literal escape decoder: one beat per character, at most one result per beat.
// Top level; depends on qled_pkg and qled_step.
//
// The block takes one source beat per clock cycle while src_stall is low and gives
// at most one result beat per input beat, through the input register and then the
// result register. Throughput is one beat per cycle as long as the result side
// does not stall; the scanner state is updated once per beat, and that state
// update is the only loop in the design. Start beats and beats that decode to
// nothing give no result. After an end marker or an error the block drops
// character and end-of-input beats until the next start beat.
module quoted_literal_escape_decoder (
  input  logic           clk,
  input  logic           rst,
  input  logic           src_valid,
  output logic           src_stall,
  input  qled_pkg::in_t  src_data,
  output logic           res_valid,
  input  logic           res_stall,
  output qled_pkg::out_t res_data
);

  logic            in_q_valid;
  qled_pkg::in_t   in_q;
  qled_pkg::scan_t scan;
  qled_pkg::scan_t scan_next;
  logic            step_emit;
  qled_pkg::out_t  step_result;
  logic            advance;

  qled_step u_step (
    .scan      (scan),
    .item      (in_q),
    .scan_next (scan_next),
    .emit      (step_emit),
    .result    (step_result)
  );

  // The held beat moves on whenever the result register is free or being drained.
  assign advance   = in_q_valid && (!res_valid || !res_stall);
  assign src_stall = in_q_valid && !advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_q_valid <= 1'b0;
    end else if (!src_stall) begin
      in_q_valid <= src_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (src_valid && !src_stall) begin
      in_q <= src_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      scan <= '0;
    end else if (advance) begin
      scan <= scan_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (advance) begin
      res_valid <= step_emit;
    end else if (!res_stall) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && step_emit) begin
      res_data <= step_result;
    end
  end

  a_close_goes_idle: assert property (@(posedge clk) disable iff (rst)
    (advance && step_emit && step_result.kind != qled_pkg::KIND_CHAR) |=> !scan.active)
    else $error("scanner still active after end marker or error");

  a_hex_count_in_run: assert property (@(posedge clk) disable iff (rst)
    (scan.hex_count != 2'd0) |-> scan.in_hex_run)
    else $error("hex digits pending outside a hex run");

  a_err_code_kind: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> ((res_data.error_code != qled_pkg::ERR_NONE) ==
                   (res_data.kind == qled_pkg::KIND_ERR)))
    else $error("error code does not match result kind");

  a_bad_char_only_hex: assert property (@(posedge clk) disable iff (rst)
    (res_valid && res_data.bad_char != 16'h0000) |->
      (res_data.error_code == qled_pkg::ERR_BAD_HEX))
    else $error("offending character reported without bad hex error");

  a_stall_holds_beat: assert property (@(posedge clk) disable iff (rst)
    src_stall |-> (in_q_valid && res_valid && res_stall))
    else $error("input stalled without a blocked result");

endmodule

>>> test/testbench.sv
// Self-checking testbench for quoted_literal_escape_decoder: directed and random literals.
// A scoreboard class predicts every result beat; depends on qled_pkg and the decoder RTL.
module testbench;

  localparam logic [1:0] ACT_UNUSED = 2'd3;
  localparam int SOURCE_BEATS = 850;

  logic           clk;
  logic           rst;
  logic           src_valid;
  logic           src_stall;
  qled_pkg::in_t  src_data;
  logic           res_valid;
  logic           res_stall;
  qled_pkg::out_t res_data;

  int src_idle_pct;
  int res_stall_pct;

  class literal_scoreboard;
    logic           active;
    logic           mode_string;
    logic           escape_pending;
    logic           in_hex_run;
    logic [1:0]     hex_count;
    logic [15:0]    hex_accum;
    qled_pkg::out_t expected_results[$];
    int             failures;
    int             beats_counted;
    int             results_checked;
    int             kind_seen[3];
    int             err_seen[5];

    function new();
      active = 1'b0;
      mode_string = 1'b0;
      clear_scan();
      failures = 0;
      beats_counted = 0;
      results_checked = 0;
      foreach (kind_seen[i]) kind_seen[i] = 0;
      foreach (err_seen[i]) err_seen[i] = 0;
    endfunction

    function void clear_scan();
      escape_pending = 1'b0;
      in_hex_run = 1'b0;
      hex_count = 2'd0;
      hex_accum = 16'h0000;
    endfunction

    // An end marker or an error closes the literal and the decoder goes idle.
    function void expect_result(qled_pkg::kind_t k, logic [15:0] c, qled_pkg::err_t e,
                                logic [15:0] bad);
      qled_pkg::out_t r;
      r.kind = k;
      r.out_char = c;
      r.error_code = e;
      r.bad_char = bad;
      expected_results.push_back(r);
      if (k != qled_pkg::KIND_CHAR) begin
        active = 1'b0;
        clear_scan();
      end
    endfunction

    function int hex_digit(logic [15:0] c);
      if (c >= "0" && c <= "9") return int'(c) - "0";
      if (c >= "a" && c <= "f") return int'(c) - "a" + 10;
      if (c >= "A" && c <= "F") return int'(c) - "A" + 10;
      return -1;
    endfunction

    function void decode_char(logic [15:0] c);
      logic [15:0] delim;
      logic [15:0] unit;
      int          digit;
      delim = mode_string ? qled_pkg::CH_QUOTE : qled_pkg::CH_BAR;
      if (escape_pending) begin
        escape_pending = 1'b0;
        if (!mode_string) begin
          if (c == qled_pkg::CH_BAR || c == qled_pkg::CH_BSLASH)
            expect_result(qled_pkg::KIND_CHAR, c, qled_pkg::ERR_NONE, 16'h0);
          else expect_result(qled_pkg::KIND_ERR, 16'h0, qled_pkg::ERR_BAD_ESC, 16'h0);
        end else if (c == qled_pkg::CH_LOWER_U || c == qled_pkg::CH_UPPER_U) begin
          if (!in_hex_run) begin
            in_hex_run = 1'b1;
            hex_count = 2'd0;
            hex_accum = 16'h0000;
          end else if (hex_count == 2'd0) begin
            in_hex_run = 1'b0;
          end else begin
            expect_result(qled_pkg::KIND_ERR, 16'h0, qled_pkg::ERR_ILLEGAL_ESC, 16'h0);
          end
        end else if (in_hex_run) begin
          expect_result(qled_pkg::KIND_ERR, 16'h0, qled_pkg::ERR_BAD_ESC, 16'h0);
        end else if (c == qled_pkg::CH_LOWER_N || c == qled_pkg::CH_UPPER_N) begin
          expect_result(qled_pkg::KIND_CHAR, qled_pkg::CODE_CR, qled_pkg::ERR_NONE, 16'h0);
        end else if (c == qled_pkg::CH_LOWER_T || c == qled_pkg::CH_UPPER_T) begin
          expect_result(qled_pkg::KIND_CHAR, qled_pkg::CODE_TAB, qled_pkg::ERR_NONE, 16'h0);
        end else begin
          expect_result(qled_pkg::KIND_CHAR, c, qled_pkg::ERR_NONE, 16'h0);
        end
      end else if (c == qled_pkg::CH_BSLASH) begin
        escape_pending = 1'b1;
      end else if (c == delim) begin
        // A delimiter part way through a four-digit group is a bad escape.
        if (in_hex_run && hex_count != 2'd0)
          expect_result(qled_pkg::KIND_ERR, 16'h0, qled_pkg::ERR_BAD_ESC, 16'h0);
        else expect_result(qled_pkg::KIND_END, 16'h0, qled_pkg::ERR_NONE, 16'h0);
      end else if (in_hex_run) begin
        digit = hex_digit(c);
        if (digit < 0) begin
          expect_result(qled_pkg::KIND_ERR, 16'h0, qled_pkg::ERR_BAD_HEX, c);
        end else begin
          unit = {hex_accum[11:0], 4'(digit)};
          if (hex_count == 2'd3) begin
            hex_count = 2'd0;
            hex_accum = 16'h0000;
            expect_result(qled_pkg::KIND_CHAR, unit, qled_pkg::ERR_NONE, 16'h0);
          end else begin
            hex_accum = unit;
            hex_count = hex_count + 2'd1;
          end
        end
      end else begin
        expect_result(qled_pkg::KIND_CHAR, c, qled_pkg::ERR_NONE, 16'h0);
      end
    endfunction

    function void note_input(qled_pkg::in_t beat);
      beats_counted++;
      if (beat.action == qled_pkg::ACT_START) begin
        active = 1'b1;
        mode_string = beat.string_mode;
        clear_scan();
      end else if (active) begin
        if (beat.action == qled_pkg::ACT_CHAR) decode_char(beat.ch);
        else if (beat.action == qled_pkg::ACT_EOF)
          expect_result(qled_pkg::KIND_ERR, 16'h0, qled_pkg::ERR_EOF, 16'h0);
      end
    endfunction

    function void check_result(qled_pkg::out_t got);
      qled_pkg::out_t want;
      if (expected_results.size() == 0) begin
        failures++;
        $error("result beat with nothing expected: kind %0d out_char %h error_code %0d",
               got.kind, got.out_char, got.error_code);
        return;
      end
      want = expected_results.pop_front();
      results_checked++;
      kind_seen[int'(want.kind)]++;
      if (want.kind == qled_pkg::KIND_ERR) err_seen[int'(want.error_code)]++;
      if (got.kind !== want.kind) begin
        failures++;
        $error("kind: expected %0d, actual %0d", want.kind, got.kind);
      end
      if (got.out_char !== want.out_char) begin
        failures++;
        $error("out_char: expected %h, actual %h", want.out_char, got.out_char);
      end
      if (got.error_code !== want.error_code) begin
        failures++;
        $error("error_code: expected %0d, actual %0d", want.error_code, got.error_code);
      end
      if (got.bad_char !== want.bad_char) begin
        failures++;
        $error("bad_char: expected %h, actual %h", want.bad_char, got.bad_char);
      end
    endfunction
  endclass

  literal_scoreboard sb;

  quoted_literal_escape_decoder i_dut (
    .clk       (clk),
    .rst       (rst),
    .src_valid (src_valid),
    .src_stall (src_stall),
    .src_data  (src_data),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res_data  (res_data)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Result side: check the beat taken at this edge, then choose the next stall.
  always @(posedge clk) begin
    if (!rst && res_valid === 1'b1 && res_stall === 1'b0) sb.check_result(res_data);
    if (rst) res_stall <= 1'b0;
    else res_stall <= ($urandom_range(99) < res_stall_pct);
  end

  task automatic send_beat(logic [1:0] action, logic smode, logic [15:0] ch);
    qled_pkg::in_t beat;
    beat.action = action;
    beat.string_mode = smode;
    beat.ch = ch;
    if (src_idle_pct != 0 && $urandom_range(99) < src_idle_pct) begin
      src_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < src_idle_pct);
    end
    src_valid <= 1'b1;
    src_data <= beat;
    do @(posedge clk); while (src_stall !== 1'b0);
    sb.note_input(beat);
  endtask

  task automatic send_start(logic smode);
    send_beat(qled_pkg::ACT_START, smode, 16'($urandom_range(16'hFFFF)));
  endtask

  task automatic send_char(logic [15:0] c);
    send_beat(qled_pkg::ACT_CHAR, 1'($urandom_range(1)), c);
  endtask

  task automatic send_eof();
    send_beat(qled_pkg::ACT_EOF, 1'($urandom_range(1)), 16'($urandom_range(16'hFFFF)));
  endtask

  task automatic send_unused();
    send_beat(ACT_UNUSED, 1'($urandom_range(1)), 16'($urandom_range(16'hFFFF)));
  endtask

  function automatic logic [15:0] pick_u();
    return $urandom_range(1) ? qled_pkg::CH_LOWER_U : qled_pkg::CH_UPPER_U;
  endfunction

  function automatic logic [15:0] rand_hex_digit();
    int d;
    d = $urandom_range(21);
    if (d < 10) return 16'("0" + d);
    if (d < 16) return 16'("a" + d - 10);
    return 16'("A" + d - 16);
  endfunction

  // Half printable text, half anywhere in the 16-bit range; never a backslash or delimiter.
  function automatic logic [15:0] plain_char(logic smode);
    logic [15:0] c;
    logic [15:0] delim;
    delim = smode ? qled_pkg::CH_QUOTE : qled_pkg::CH_BAR;
    do begin
      c = $urandom_range(1) ? 16'($urandom_range(16'h20, 16'h7E))
                            : 16'($urandom_range(16'hFFFF));
    end while (c == qled_pkg::CH_BSLASH || c == delim);
    return c;
  endfunction

  function automatic logic [15:0] escaped_char(logic smode);
    logic [15:0] c;
    if (!smode) return $urandom_range(1) ? qled_pkg::CH_BAR : qled_pkg::CH_BSLASH;
    do begin
      case ($urandom_range(9))
        0: c = qled_pkg::CH_LOWER_N;
        1: c = qled_pkg::CH_UPPER_N;
        2: c = qled_pkg::CH_LOWER_T;
        3: c = qled_pkg::CH_UPPER_T;
        4: c = qled_pkg::CH_QUOTE;
        5: c = qled_pkg::CH_BAR;
        6: c = qled_pkg::CH_BSLASH;
        7: c = 16'($urandom_range(16'h20, 16'h7E));
        default: c = 16'($urandom_range(16'hFFFF));
      endcase
    end while (c == qled_pkg::CH_LOWER_U || c == qled_pkg::CH_UPPER_U);
    return c;
  endfunction

  function automatic logic [15:0] noise_char();
    case ($urandom_range(9))
      0: return qled_pkg::CH_BSLASH;
      1: return qled_pkg::CH_QUOTE;
      2: return qled_pkg::CH_BAR;
      3: return pick_u();
      4: return qled_pkg::CH_LOWER_N;
      5: return qled_pkg::CH_LOWER_T;
      6: return rand_hex_digit();
      7: return 16'("g");
      default: return 16'($urandom_range(16'hFFFF));
    endcase
  endfunction

  task automatic send_noise(int n);
    int r;
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(99);
      if (r < 8) send_start(1'($urandom_range(1)));
      else if (r < 18) send_eof();
      else if (r < 23) send_unused();
      else send_char(noise_char());
    end
  endtask

  task automatic send_hex_digits(int n);
    for (int i = 0; i < n; i++) send_char(rand_hex_digit());
  endtask

  // Mostly well-formed literals; about one in five is cut short and followed by noise.
  task automatic send_random_literal();
    logic smode;
    bit   broken;
    bit   run_open;
    int   tokens;
    int   pick;
    smode = 1'($urandom_range(1));
    broken = ($urandom_range(99) < 20);
    tokens = $urandom_range(10);
    run_open = 1'b0;
    send_start(smode);
    for (int t = 0; t < tokens && !run_open; t++) begin
      pick = $urandom_range(9);
      if (pick < 5) begin
        send_char(plain_char(smode));
      end else if (!smode || pick < 8) begin
        send_char(qled_pkg::CH_BSLASH);
        send_char(escaped_char(smode));
      end else begin
        send_char(qled_pkg::CH_BSLASH);
        send_char(pick_u());
        send_hex_digits(4 * $urandom_range(3));
        if ($urandom_range(3) != 0) begin
          send_char(qled_pkg::CH_BSLASH);
          send_char(pick_u());
        end else begin
          run_open = 1'b1;
        end
      end
    end
    if (broken) begin
      if (smode && !run_open && $urandom_range(1)) begin
        send_char(qled_pkg::CH_BSLASH);
        send_char(pick_u());
        send_hex_digits($urandom_range(3));
      end
      send_noise($urandom_range(1, 4));
    end else begin
      send_char(smode ? qled_pkg::CH_QUOTE : qled_pkg::CH_BAR);
    end
  endtask

  task automatic send_directed();
    send_start(1'b1);
    send_char(16'("a"));
    send_char(16'hFFFF);
    send_char(qled_pkg::CH_BSLASH); send_char(qled_pkg::CH_LOWER_N);
    send_char(qled_pkg::CH_BSLASH); send_char(qled_pkg::CH_UPPER_T);
    send_char(qled_pkg::CH_BSLASH); send_char(qled_pkg::CH_LOWER_U);
    send_char(16'("F")); send_char(16'("0")); send_char(16'("a")); send_char(16'("9"));
    send_char(qled_pkg::CH_BSLASH); send_char(qled_pkg::CH_UPPER_U);
    // Reopened run with no digits, so the quote ends the literal normally.
    send_char(qled_pkg::CH_BSLASH); send_char(qled_pkg::CH_LOWER_U);
    send_char(qled_pkg::CH_QUOTE);
    send_char(16'("z"));
    send_start(1'b0);
    send_char(qled_pkg::CH_BSLASH); send_char(qled_pkg::CH_BAR);
    send_start(1'b1);
    send_unused();
    send_eof();
    // Second hex escape while a group is half gathered.
    send_start(1'b1);
    send_char(qled_pkg::CH_BSLASH); send_char(qled_pkg::CH_UPPER_U); send_char(16'("7"));
    send_char(qled_pkg::CH_BSLASH); send_char(qled_pkg::CH_LOWER_U);
    send_start(1'b1);
    send_char(qled_pkg::CH_BSLASH); send_char(qled_pkg::CH_LOWER_U); send_char(16'("G"));
  endtask

  initial begin
    int drain;
    sb = new();
    src_idle_pct = 0;
    res_stall_pct = 0;
    rst <= 1'b1;
    src_valid <= 1'b0;
    src_data <= '0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin src_idle_pct = 0;  res_stall_pct = 0;  end
        1: begin src_idle_pct = 67; res_stall_pct = 0;  end
        2: begin src_idle_pct = 0;  res_stall_pct = 67; end
        default: begin src_idle_pct = 12; res_stall_pct = 12; end
      endcase
      if (phase == 0) send_directed();
      while (sb.beats_counted < (phase + 1) * SOURCE_BEATS / 4) begin
        if ($urandom_range(9) == 0) send_char(plain_char(1'($urandom_range(1))));
        send_random_literal();
      end
    end
    src_valid <= 1'b0;
    drain = 0;
    while (sb.expected_results.size() != 0 && drain < 5000) begin
      @(posedge clk);
      drain++;
    end
    repeat (10) @(posedge clk);
    if (sb.expected_results.size() != 0) begin
      sb.failures += sb.expected_results.size();
      $error("%0d expected result beats never arrived", sb.expected_results.size());
    end
    $display("Covered %0d source beats over four idle/stall phases; %0d result beats checked.",
             sb.beats_counted, sb.results_checked);
    $display("Units %0d, ends %0d, errors %0d (eof %0d, illegal %0d, bad escape %0d, bad hex %0d).",
             sb.kind_seen[0], sb.kind_seen[1], sb.kind_seen[2], sb.err_seen[1], sb.err_seen[2],
             sb.err_seen[3], sb.err_seen[4]);
    if (sb.failures == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end

  initial begin
    #(12 * 500000);
    $display("testbench NOT OK");
    $finish;
  end

endmodule

>>> quoted_literal_escape_decoder.f
rtl/qled_pkg.sv
rtl/qled_step.sv
rtl/quoted_literal_escape_decoder.sv
test/testbench.sv
